>>> hdl/cubic_bspline_path_follower_defines.svh
// Assertion macros used by the checker file.
`ifndef CUBIC_BSPLINE_PATH_FOLLOWER_DEFINES_SVH
`define CUBIC_BSPLINE_PATH_FOLLOWER_DEFINES_SVH
// Implication check, cycle-delayed form.
`define CBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
// Implication check, same-cycle form.
`define CBS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`endif

>>> hdl/cbs_pkg.sv
// ----------------------------------------------------------------------------
// cbs_pkg
// Types and constants shared by the B-spline path follower modules.
// ----------------------------------------------------------------------------
package cbs_pkg;
    localparam logic [2:0] CMD_WRITE   = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_TICK    = 3'd2;
    localparam logic [2:0] CMD_SPEED   = 3'd3;
    localparam logic [2:0] CMD_STOP    = 3'd4;
    localparam logic [2:0] CMD_RESTART = 3'd5;

    localparam logic [16:0] Q16_ONE = 17'd65536;

    // Request to the shared multiplier: start strobe and operands.
    typedef struct packed {
        logic        start;
        logic [35:0] a;
        logic [35:0] b;
    } t_mul_req;
endpackage

>>> hdl/cbs_mul.sv
// ----------------------------------------------------------------------------
// cbs_mul
// Shared registered signed multiplier, 36 x 36 via halves.
// ----------------------------------------------------------------------------
module cbs_mul
    import cbs_pkg::*;
(
    input  logic               i_clk,
    input  t_mul_req           i_req,
    output logic signed [71:0] o_prod
);
    // a is split into a signed high part and an unsigned 18-bit low part.
    logic signed [35:0] r_b;
    logic signed [17:0] r_ahi;
    logic        [17:0] r_alo;
    logic signed [53:0] r_plo;
    logic signed [53:0] r_phi;
    logic signed [71:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_b   <= signed'(i_req.b);
            r_ahi <= signed'(i_req.a[35:18]);
            r_alo <= i_req.a[17:0];
        end
        r_plo  <= r_b * signed'({1'b0, r_alo});
        r_phi  <= r_b * r_ahi;
        r_prod <= (72'(r_phi) <<< 18) + 72'(r_plo);
    end
    assign o_prod = r_prod;
endmodule

>>> hdl/cubic_bspline_path_follower.sv
// ----------------------------------------------------------------------------
// cubic_bspline_path_follower
// Uniform cubic B-spline path follower with a shared multiplier sequencer.
// ----------------------------------------------------------------------------
// Channel | Signals                                   | Direction
// input   | i_valid/o_ready, cmd and point fields     | in
// output  | o_valid/i_ready, pos, vel, active         | out
// A tick that blends forms t^2, t^3, u^2 and u^3 on the multiplier, divides
// for the four weights, then runs the twelve products, one operation at a
// time. A start reads entry 0 first; a clamped end reads the last entry.
// The point table is read through one port, one entry per cycle.
// Reset is synchronous; the table itself is not cleared.
// The block accepts no beat while a result waits in the output register.
module cubic_bspline_path_follower
    import cbs_pkg::*;
#(
    parameter int MAX_POINTS  = 256,
    parameter int COORD_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [2:0]          i_cmd,
    input  logic [7:0]          i_point_index,
    input  logic signed [31:0]  i_coord_x,
    input  logic signed [31:0]  i_coord_y,
    input  logic signed [31:0]  i_coord_z,
    input  logic [7:0]          i_point_count,
    input  logic                i_loop_mode,
    input  logic                i_with_offset,
    input  logic [16:0]         i_speed,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [31:0]  o_pos_x,
    output logic signed [31:0]  o_pos_y,
    output logic signed [31:0]  o_pos_z,
    output logic signed [31:0]  o_vel_x,
    output logic signed [31:0]  o_vel_y,
    output logic signed [31:0]  o_vel_z,
    output logic                o_active
);
    localparam int CW = COORD_WIDTH;
    localparam int AW = $clog2(MAX_POINTS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD0   = 4'd1;  // read entry 0 for start
    localparam logic [3:0] S_STRT  = 4'd2;
    localparam logic [3:0] S_WMUL  = 4'd3;  // weight multiplies
    localparam logic [3:0] S_WFIN  = 4'd4;  // weight divides
    localparam logic [3:0] S_PRD   = 4'd5;  // gather point
    localparam logic [3:0] S_PMUL  = 4'd6;  // product accumulate
    localparam logic [3:0] S_DONE  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_CLRD  = 4'd9;  // clamp end read
    localparam logic [3:0] S_CLMP  = 4'd10;

    // Division by six: halve, then multiply by a scaled reciprocal of three.
    function automatic logic [17:0] div6(input logic [19:0] x);
        logic [38:0] p;
        p = 39'(x[19:1]) * 39'd349526;
        return 18'(p >> 20);
    endfunction

    logic [CW-1:0] r_mem_x [MAX_POINTS];
    logic [CW-1:0] r_mem_y [MAX_POINTS];
    logic [CW-1:0] r_mem_z [MAX_POINTS];
    logic [CW-1:0] r_rd_x, r_rd_y, r_rd_z;
    logic [AW-1:0] n_rd_addr;
    logic          n_rd_en;

    logic [3:0]  r_state, n_state;
    logic [CW-1:0] r_pos [3];
    logic [CW-1:0] r_off [3];
    logic [CW-1:0] r_old [3];
    logic [16:0] r_ratio;
    logic [8:0]  r_seg;
    logic [7:0]  r_count;
    logic [16:0] r_step;
    logic        r_act, r_loop, r_offm;
    logic        r_ovalid;

    // Weight computation state.
    logic [2:0]  r_wstep;
    logic [1:0]  r_wait;
    logic [16:0] r_t2, r_t3, r_u2, r_u3;
    logic [17:0] r_w [4];
    logic [1:0]  r_pi;      // which neighbor
    logic [1:0]  r_ci;      // which coordinate
    logic [CW-1:0] w_pt;
    logic signed [71:0] r_acc [3];

    t_mul_req           w_req;
    logic signed [71:0] w_prod;

    cbs_mul u_mul (.i_clk(i_clk), .i_req(w_req), .o_prod(w_prod));

    logic [8:0] w_n;
    assign w_n = (r_count == 8'd0) ? 9'd1 :
                 ((9'(r_count) > 9'(MAX_POINTS)) ? 9'(MAX_POINTS) : 9'(r_count));

    logic [16:0] w_t, w_u;
    assign w_t = (r_ratio > Q16_ONE) ? Q16_ONE : r_ratio;
    assign w_u = Q16_ONE - w_t;

    // Neighbor index, wrap or clamp; k = seg + pi - 1 stays within 2n.
    logic signed [10:0] w_k, w_kw;
    logic [8:0]         w_kidx;
    always_comb begin
        w_k  = signed'(11'(r_seg)) + signed'(11'(r_pi)) - 11'sd1;
        w_kw = w_k;
        if (r_loop) begin
            if (w_kw < 0) w_kw = w_kw + signed'(11'(w_n));
            if (w_kw >= signed'(11'(w_n))) w_kw = w_kw - signed'(11'(w_n));
            if (w_kw >= signed'(11'(w_n))) w_kw = w_kw - signed'(11'(w_n));
            if (w_kw >= signed'(11'(w_n))) w_kw = w_kw - signed'(11'(w_n));
        end else begin
            if (w_kw > signed'(11'(w_n)) - 11'sd1) w_kw = signed'(11'(w_n)) - 11'sd1;
            if (w_kw < 0) w_kw = 11'sd0;
        end
        w_kidx = w_kw[8:0];
    end

    // Weight numerators (never negative).
    logic [19:0] w_n1, w_n2;
    assign w_n1 = 20'(3 * 20'(r_t3)) - 20'(6 * 20'(r_t2)) + 20'd262144;
    assign w_n2 = 20'(3 * (20'(r_t2) + 20'(w_t) - 20'(r_t3))) + 20'd65536;

    logic [CW-1:0] w_sum [3];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_sum[c] = CW'(r_acc[c] >>> 16) + (r_offm ? r_off[c] : '0);
        end
    end

    // The neighbor read stays in r_rd_* for all of its product beats.
    assign w_pt = (r_ci == 2'd0) ? r_rd_x : ((r_ci == 2'd1) ? r_rd_y : r_rd_z);

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;

    always_comb begin
        n_rd_en   = 1'b0;
        n_rd_addr = '0;
        unique case (r_state)
            S_RD0:  n_rd_en = 1'b1;
            S_PRD:  begin n_rd_en = 1'b1; n_rd_addr = AW'(w_kidx); end
            S_CLRD: begin n_rd_en = 1'b1; n_rd_addr = AW'(w_n - 9'd1); end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready && i_cmd == CMD_WRITE && 32'(i_point_index) < MAX_POINTS) begin
            r_mem_x[AW'(i_point_index)] <= i_coord_x[CW-1:0];
            r_mem_y[AW'(i_point_index)] <= i_coord_y[CW-1:0];
            r_mem_z[AW'(i_point_index)] <= i_coord_z[CW-1:0];
        end
        if (n_rd_en) begin
            r_rd_x <= r_mem_x[n_rd_addr];
            r_rd_y <= r_mem_y[n_rd_addr];
            r_rd_z <= r_mem_z[n_rd_addr];
        end
    end

    // Multiplier request selection.
    always_comb begin
        w_req = '0;
        if (r_state == S_WMUL && r_wait == 2'd0) begin
            w_req.start = 1'b1;
            unique case (r_wstep)
                3'd0: begin w_req.a = 36'(w_t);  w_req.b = 36'(w_t);  end
                3'd1: begin w_req.a = 36'(r_t2); w_req.b = 36'(w_t);  end
                3'd2: begin w_req.a = 36'(w_u);  w_req.b = 36'(w_u);  end
                default: begin w_req.a = 36'(r_u2); w_req.b = 36'(w_u); end
            endcase
        end else if (r_state == S_PMUL && r_wait == 2'd0) begin
            w_req.start = 1'b1;
            w_req.a = 36'(r_w[r_pi]);
            w_req.b = 36'(signed'(w_pt));
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid && o_ready) begin
                if (i_cmd == CMD_START) n_state = S_RD0;
                else if (i_cmd == CMD_TICK && r_act) begin
                    if (r_loop ? (r_seg > w_n - 9'd1) : (r_seg > w_n)) begin
                        n_state = r_loop ? S_OUT : S_CLRD;
                    end else n_state = S_WMUL;
                end else n_state = S_OUT;
            end
            S_RD0:  n_state = S_STRT;
            S_STRT: n_state = S_OUT;
            S_WMUL: if (r_wait == 2'd3 && r_wstep == 3'd3) n_state = S_WFIN;
            S_WFIN: n_state = S_PRD;
            S_PRD:  n_state = S_PMUL;
            S_PMUL: if (r_wait == 2'd3 && r_ci == 2'd2)
                        n_state = (r_pi == 2'd3) ? S_DONE : S_PRD;
            S_DONE: n_state = S_OUT;
            S_CLRD: n_state = S_CLMP;
            S_CLMP: n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_act    <= 1'b0;
            r_loop   <= 1'b0;
            r_offm   <= 1'b0;
            r_ratio  <= '0;
            r_seg    <= '0;
            r_count  <= '0;
            r_step   <= '0;
            r_wait   <= '0;
            r_wstep  <= '0;
            r_pi     <= '0;
            r_ci     <= '0;
            for (int c = 0; c < 3; c++) begin
                r_pos[c] <= '0;
                r_off[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid && o_ready) begin
                    for (int c = 0; c < 3; c++) r_old[c] <= r_pos[c];
                    r_wait <= '0; r_wstep <= '0; r_pi <= '0; r_ci <= '0;
                    for (int c = 0; c < 3; c++) r_acc[c] <= '0;
                    unique case (i_cmd)
                        CMD_START: begin
                            r_count <= i_point_count;
                            r_loop  <= i_loop_mode;
                            r_offm  <= i_with_offset;
                            r_step  <= (i_speed > Q16_ONE) ? Q16_ONE : i_speed;
                            r_act   <= 1'b1;
                            r_seg   <= '0;
                            r_ratio <= '0;
                        end
                        CMD_TICK: if (r_act && r_loop && r_seg > w_n - 9'd1) r_seg <= '0;
                        CMD_SPEED: r_step <= (i_speed > Q16_ONE) ? Q16_ONE : i_speed;
                        CMD_STOP: r_act <= 1'b0;
                        CMD_RESTART: r_act <= 1'b1;
                        default: ;
                    endcase
                end
                S_STRT: begin
                    r_off[0] <= r_offm ? r_pos[0] : '0;
                    r_off[1] <= r_offm ? r_pos[1] : '0;
                    r_off[2] <= r_offm ? r_pos[2] : '0;
                    r_pos[0] <= (r_offm ? r_pos[0] : '0) + r_rd_x;
                    r_pos[1] <= (r_offm ? r_pos[1] : '0) + r_rd_y;
                    r_pos[2] <= (r_offm ? r_pos[2] : '0) + r_rd_z;
                end
                S_WMUL: begin
                    r_wait <= r_wait + 2'd1;
                    if (r_wait == 2'd3) begin
                        unique case (r_wstep)
                            3'd0: r_t2 <= 17'(w_prod >>> 16);
                            3'd1: r_t3 <= 17'(w_prod >>> 16);
                            3'd2: r_u2 <= 17'(w_prod >>> 16);
                            default: r_u3 <= 17'(w_prod >>> 16);
                        endcase
                        r_wstep <= r_wstep + 3'd1;
                    end
                end
                S_WFIN: begin
                    r_w[0] <= div6(20'(r_u3));
                    r_w[1] <= div6(w_n1);
                    r_w[2] <= div6(w_n2);
                    r_w[3] <= div6(20'(r_t3));
                end
                S_PRD: r_wait <= '0;
                S_PMUL: begin
                    r_wait <= r_wait + 2'd1;
                    if (r_wait == 2'd3) begin
                        r_acc[r_ci] <= r_acc[r_ci] + w_prod;
                        r_ci <= (r_ci == 2'd2) ? 2'd0 : r_ci + 2'd1;
                        if (r_ci == 2'd2) r_pi <= r_pi + 2'd1;
                    end
                end
                S_DONE: begin
                    for (int c = 0; c < 3; c++) r_pos[c] <= w_sum[c];
                    if (18'(r_ratio) + 18'(r_step) > 18'(Q16_ONE)) begin
                        r_ratio <= 17'(18'(r_ratio) + 18'(r_step) - 18'(Q16_ONE));
                        r_seg   <= r_seg + 9'd1;
                    end else r_ratio <= r_ratio + r_step;
                end
                S_CLMP: begin
                    r_pos[0] <= r_rd_x; r_pos[1] <= r_rd_y; r_pos[2] <= r_rd_z;
                    r_act <= 1'b0;
                end
                S_OUT: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

    assign o_valid  = r_ovalid;
    assign o_pos_x  = 32'(signed'(r_pos[0]));
    assign o_pos_y  = 32'(signed'(r_pos[1]));
    assign o_pos_z  = 32'(signed'(r_pos[2]));
    assign o_vel_x  = 32'(signed'(r_pos[0])) - 32'(signed'(r_old[0]));
    assign o_vel_y  = 32'(signed'(r_pos[1])) - 32'(signed'(r_old[1]));
    assign o_vel_z  = 32'(signed'(r_pos[2])) - 32'(signed'(r_old[2]));
    assign o_active = r_act;
endmodule

>>> hdl/cbs_checker.sv
// ----------------------------------------------------------------------------
// cbs_checker
// Port-level checks for the B-spline path follower.
// ----------------------------------------------------------------------------
`include "cubic_bspline_path_follower_defines.svh"
module cbs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_active
);
    // A result beat must wait while it is not taken.
    `CBS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    // Input is never taken while a result waits.
    `CBS_ASSERT_SAME(a_block, i_clk, i_rst_n, o_valid, !o_ready)
    // One accepted beat closes the ready window.
    `CBS_ASSERT_NEXT(a_one, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    // Active holds while the block is ready and no beat is offered.
    `CBS_ASSERT_NEXT(a_act, i_clk, i_rst_n, o_ready && !i_valid, $stable(o_active))
endmodule

bind cubic_bspline_path_follower cbs_checker u_cbs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_active(o_active)
);

>>> bench/tb_cubic_bspline_path_follower.sv
// ----------------------------------------------------------------------------
// tb_cubic_bspline_path_follower
// Self-checking bench for the B-spline path follower. Command beats are
// queued, driven with random gaps and checked beat by beat against an
// in-bench predictor of the position, velocity and active flag.
// ----------------------------------------------------------------------------
module tb_cubic_bspline_path_follower;
    import cbs_pkg::*;

    localparam int WATCHDOG = 5000;
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    typedef struct {
        logic [2:0]  cmd;
        logic [7:0]  idx;
        logic [31:0] cx, cy, cz;
        logic [7:0]  cnt;
        logic        lp, ofs;
        logic [16:0] spd;
        bit          drain;
    } t_cmd_beat;

    typedef struct {
        logic [31:0] pos [3];
        logic [31:0] vel [3];
        logic        act;
    } t_motion;

    logic i_clk = 0, i_rst_n = 0, i_valid = 0, i_ready = 0;
    logic [2:0]  i_cmd = '0;
    logic [7:0]  i_point_index = '0, i_point_count = '0;
    logic signed [31:0] i_coord_x = '0, i_coord_y = '0, i_coord_z = '0;
    logic i_loop_mode = 0, i_with_offset = 0;
    logic [16:0] i_speed = '0;
    logic o_ready, o_valid, o_active;
    logic signed [31:0] o_pos_x, o_pos_y, o_pos_z, o_vel_x, o_vel_y, o_vel_z;

    cubic_bspline_path_follower uut (.*);

    always #1 i_clk = ~i_clk;

    t_cmd_beat pending_cmds [$];
    t_motion   expected_motion [$];
    bit        errors = 0;
    bit        quiet = 0;
    int        results_seen = 0;

    // Predictor state.
    longint pt_store [256][3];
    longint cur_pos [3], base_pos [3];
    int     t_ratio = 0, seg = 0, n_used = 0, step = 0;
    bit     act_f = 0, loop_f = 0, ofs_f = 0;

    function automatic longint wrap32(longint v);
        return longint'($signed(v[31:0]));
    endfunction

    function automatic longint eff_points();
        return (n_used < 1) ? 1 : n_used;
    endfunction

    task automatic blend_point();
        longint t, u, t2, t3, u2, u3, n, k, s;
        longint w [4];
        longint ix [4];
        t = (t_ratio > 65536) ? 65536 : t_ratio;
        u = 65536 - t;
        t2 = (t * t) >> 16;
        t3 = (t2 * t) >> 16;
        u2 = (u * u) >> 16;
        u3 = (u2 * u) >> 16;
        w[0] = u3 / 6;
        w[1] = (3 * t3 - 6 * t2 + 262144) / 6;
        w[2] = (3 * (t2 + t - t3) + 65536) / 6;
        w[3] = t3 / 6;
        n = eff_points();
        for (int i = 0; i < 4; i++) begin
            k = seg + i - 1;
            if (loop_f) k = (k + n) % n;
            else begin
                if (k > n - 1) k = n - 1;
                if (k < 0) k = 0;
            end
            ix[i] = k;
        end
        for (int c = 0; c < 3; c++) begin
            s = 0;
            for (int i = 0; i < 4; i++) s += w[i] * pt_store[ix[i]][c];
            s = s >>> 16;
            if (ofs_f) s += base_pos[c];
            cur_pos[c] = wrap32(s);
        end
    endtask

    task automatic predict_motion(input t_cmd_beat b, output t_motion m);
        longint prev [3];
        longint n;
        bit reached;
        prev = cur_pos;
        case (b.cmd)
            CMD_WRITE: begin
                pt_store[b.idx][0] = longint'($signed(b.cx));
                pt_store[b.idx][1] = longint'($signed(b.cy));
                pt_store[b.idx][2] = longint'($signed(b.cz));
            end
            CMD_START: begin
                n_used = b.cnt;
                loop_f = b.lp;
                ofs_f = b.ofs;
                step = (b.spd > Q16_ONE) ? 65536 : int'(b.spd);
                act_f = 1;
                seg = 0;
                t_ratio = 0;
                for (int c = 0; c < 3; c++) begin
                    if (ofs_f) begin
                        base_pos[c] = cur_pos[c];
                        cur_pos[c] = wrap32(cur_pos[c] + pt_store[0][c]);
                    end else begin
                        base_pos[c] = 0;
                        cur_pos[c] = pt_store[0][c];
                    end
                end
            end
            CMD_TICK: if (act_f) begin
                n = eff_points();
                reached = loop_f ? (seg > n - 1) : (seg > n);
                if (reached) begin
                    if (loop_f) seg = 0;
                    else begin
                        for (int c = 0; c < 3; c++) cur_pos[c] = pt_store[n - 1][c];
                        act_f = 0;
                    end
                end else begin
                    blend_point();
                    t_ratio += step;
                    if (t_ratio > 65536) begin
                        t_ratio -= 65536;
                        seg = (seg + 1) & 'h1FF;
                    end
                end
            end
            CMD_SPEED: step = (b.spd > Q16_ONE) ? 65536 : int'(b.spd);
            CMD_STOP: act_f = 0;
            CMD_RESTART: act_f = 1;
            default: ;
        endcase
        for (int c = 0; c < 3; c++) begin
            m.pos[c] = cur_pos[c][31:0];
            m.vel[c] = 32'(cur_pos[c] - prev[c]);
        end
        m.act = act_f;
    endtask

    // Stimulus side bookkeeping: which table entries are loaded.
    bit loaded [256];
    int prefix = 0;

    function automatic t_cmd_beat rand_beat(logic [2:0] cmd);
        t_cmd_beat b;
        b.cmd = cmd;
        b.idx = 8'($urandom);
        b.cx = $urandom; b.cy = $urandom; b.cz = $urandom;
        b.cnt = 8'($urandom);
        b.lp = 1'($urandom); b.ofs = 1'($urandom);
        b.spd = 17'($urandom);
        b.drain = 0;
        return b;
    endfunction

    task automatic queue_write(int idx, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_cmd_beat b;
        b = rand_beat(CMD_WRITE);
        b.idx = 8'(idx); b.cx = x; b.cy = y; b.cz = z;
        pending_cmds.push_back(b);
        loaded[idx] = 1;
        while (prefix < 256 && loaded[prefix]) prefix++;
    endtask

    task automatic queue_start(int cnt, bit lp, bit ofs, int spd);
        t_cmd_beat b;
        b = rand_beat(CMD_START);
        b.cnt = 8'(cnt); b.lp = lp; b.ofs = ofs; b.spd = 17'(spd);
        pending_cmds.push_back(b);
    endtask

    task automatic queue_plain(logic [2:0] cmd, int reps);
        for (int i = 0; i < reps; i++) pending_cmds.push_back(rand_beat(cmd));
    endtask

    task automatic random_coord(output logic [31:0] v);
        case ($urandom_range(0, 9))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2, 3: v = $urandom;
            default: v = 32'($signed($urandom_range(0, 40000)) - 20000);
        endcase
    endtask

    initial begin : stimulus
        logic [31:0] x, y, z;
        t_cmd_beat b;
        int cmax, r;
        bit drain_queued;
        drain_queued = 0;
        // Directed part.
        queue_write(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0100);
        queue_plain(CMD_RESTART, 1);    // restart with nothing started yet
        queue_plain(CMD_TICK, 2);
        queue_plain(CMD_STOP, 1);
        queue_plain(CMD_TICK, 1);       // tick while inactive
        queue_plain(CMD_SPARE6, 1);
        queue_plain(CMD_SPARE7, 1);
        queue_write(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FF00);
        queue_write(2, 32'h0000_1000, 32'h0000_2000, 32'h0000_3000);
        queue_write(3, 32'hFFFF_F000, 32'h0000_0800, 32'h0000_0000);
        queue_start(0, 1, 0, 40000);    // count of zero acts as one point
        queue_plain(CMD_TICK, 3);
        queue_start(4, 1, 1, 65536);    // loop with offset, full-step speed
        b = rand_beat(CMD_SPEED); b.spd = 17'h1FFFF; pending_cmds.push_back(b);
        queue_plain(CMD_TICK, 6);       // wraps at loop end
        queue_start(4, 0, 0, 131071);   // clamp, speed saturates
        queue_plain(CMD_TICK, 7);       // snaps to last point and stops
        // Random part.
        while (pending_cmds.size() < 600) begin
            if (pending_cmds.size() > 300 && prefix < 256) begin
                // Load the whole table once so large counts can be used.
                while (prefix < 256) begin
                    random_coord(x); random_coord(y); random_coord(z);
                    queue_write(prefix, x, y, z);
                end
                queue_start($urandom_range(128, 255), 1'($urandom), 1'($urandom),
                            int'($urandom));
                queue_plain(CMD_TICK, 10);
                queue_start(255, 1, 0, 65536);
                queue_plain(CMD_TICK, 5);
            end
            r = $urandom_range(0, 99);
            if (r < 30) begin
                random_coord(x); random_coord(y); random_coord(z);
                if (prefix < 256 && $urandom_range(0, 2) != 0) queue_write(prefix, x, y, z);
                else queue_write($urandom_range(0, 255), x, y, z);
            end else if (r < 42 && prefix > 0) begin
                cmax = (prefix > 10) ? 10 : prefix;
                queue_start($urandom_range(0, cmax), 1'($urandom), 1'($urandom),
                            ($urandom_range(0, 7) == 0) ? $urandom_range(0, 131071)
                                                        : $urandom_range(8000, 65536));
            end else if (r < 80 && prefix > 0) begin
                queue_plain(CMD_TICK, $urandom_range(1, 10));
            end else if (r < 86) begin
                queue_plain(CMD_SPEED, 1);
            end else if (r < 91) begin
                queue_plain(CMD_STOP, 1);
            end else if (r < 97 && prefix > 0) begin
                queue_plain(CMD_RESTART, 1);
            end else begin
                queue_plain($urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7, 1);
            end
            if (!drain_queued && pending_cmds.size() >= 400) begin
                // The sender holds this beat until every result is back.
                b = rand_beat(CMD_TICK);
                b.drain = 1;
                pending_cmds.push_back(b);
                drain_queued = 1;
            end
        end
    end

    // Reset and end of run.
    initial begin : run_control
        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        wait (pending_cmds.size() == 0 && !i_valid && expected_motion.size() == 0);
        repeat (200) @(posedge i_clk);
        if (!errors && expected_motion.size() == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

    // Input monitor: every accepted command beat feeds the predictor.
    bit cmd_taken = 0;
    int send_gap = 0;
    always @(posedge i_clk) begin
        t_motion m;
        t_cmd_beat b;
        cmd_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            b.cmd = i_cmd; b.idx = i_point_index;
            b.cx = i_coord_x; b.cy = i_coord_y; b.cz = i_coord_z;
            b.cnt = i_point_count; b.lp = i_loop_mode; b.ofs = i_with_offset;
            b.spd = i_speed;
            b.drain = 0;
            predict_motion(b, m);
            expected_motion.push_back(m);
        end
    end

    // Input driver.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            quiet = pending_cmds.size() < 80;
            if (!i_valid || cmd_taken) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 9) == 0) begin
                    send_gap <= $urandom_range(0, 7);
                    i_valid <= 1'b0;
                end else if (pending_cmds.size() == 0 ||
                             (pending_cmds[0].drain && expected_motion.size() != 0)) begin
                    i_valid <= 1'b0;
                end else begin
                    t_cmd_beat b;
                    b = pending_cmds.pop_front();
                    i_valid <= 1'b1;
                    i_cmd <= b.cmd; i_point_index <= b.idx;
                    i_coord_x <= b.cx; i_coord_y <= b.cy; i_coord_z <= b.cz;
                    i_point_count <= b.cnt; i_loop_mode <= b.lp;
                    i_with_offset <= b.ofs; i_speed <= b.spd;
                end
            end
        end
    end

    // Output side: ready with bursts of back-pressure and one long hold.
    int recv_gap = 0;
    bit long_hold_done = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_ready <= 1'b0;
        end else if (!long_hold_done && results_seen >= 200) begin
            long_hold_done <= 1'b1;
            recv_gap <= 300;
            i_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(0, 7);
            i_ready <= 1'b0;
        end else i_ready <= 1'b1;
    end

    // Result checker and watchdog.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        t_motion m;
        logic [31:0] got_pos [3];
        logic [31:0] got_vel [3];
        if (i_rst_n) begin
            idle_cycles <= (i_valid && o_ready) || (o_valid && i_ready) ? 0 : idle_cycles + 1;
            if (idle_cycles > WATCHDOG) begin
                $display("[FAIL] regression broken");
                $finish;
            end
            if (o_valid && i_ready) begin
                results_seen <= results_seen + 1;
                got_pos = '{o_pos_x, o_pos_y, o_pos_z};
                got_vel = '{o_vel_x, o_vel_y, o_vel_z};
                if (expected_motion.size() == 0) begin
                    $display("%0t: unexpected result beat, pos %h %h %h", $time,
                             o_pos_x, o_pos_y, o_pos_z);
                    errors = 1;
                end else begin
                    m = expected_motion.pop_front();
                    for (int c = 0; c < 3; c++) begin
                        if (got_pos[c] !== m.pos[c]) begin
                            $display("%0t: pos[%0d] expected %h actual %h", $time, c,
                                     m.pos[c], got_pos[c]);
                            errors = 1;
                        end
                        if (got_vel[c] !== m.vel[c]) begin
                            $display("%0t: vel[%0d] expected %h actual %h", $time, c,
                                     m.vel[c], got_vel[c]);
                            errors = 1;
                        end
                    end
                    if (o_active !== m.act) begin
                        $display("%0t: active expected %b actual %b", $time, m.act, o_active);
                        errors = 1;
                    end
                end
            end
        end
    end
endmodule

>>> filelist.f
+incdir+hdl
hdl/cbs_pkg.sv
hdl/cbs_mul.sv
hdl/cubic_bspline_path_follower.sv
hdl/cbs_checker.sv
bench/tb_cubic_bspline_path_follower.sv
